[rtl/gconv_pkg.sv]
// shared types, sizes and codes for the 5x5 gray convolution filter
// no dependencies; imported by every other file of the block

package gconv_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int CH_W      = 8;
    localparam int PIX_W     = 16;
    localparam int COL_W     = 10;
    localparam int ROW_W     = 12;
    localparam int WREG_W    = 11;
    localparam int HREG_W    = 13;
    localparam int COEF_W    = 12;
    localparam int KSIZE     = 5;
    localparam int KROW_W    = COEF_W * KSIZE;
    localparam int LINES     = 4;
    localparam int SLOT_W    = 2;
    localparam int PROD_W    = PIX_W + 1 + COEF_W;
    localparam int RSUM_W    = PROD_W + 3;
    localparam int SUM_W     = PROD_W + 5;
    localparam int FRAC_W    = 8;
    localparam int CONV_W    = 25;
    localparam int CFG_IDX_W = 4;
    localparam int PIPE_DEPTH = 6;

    localparam logic [CH_W-1:0] GRAY_WR = 8'd77;
    localparam logic [CH_W-1:0] GRAY_WG = 8'd151;
    localparam logic [CH_W-1:0] GRAY_WB = 8'd28;

    localparam logic [WREG_W-1:0] WIDTH_MAX  = WREG_W'(MAX_WIDTH);
    localparam logic [HREG_W-1:0] HEIGHT_MAX = HREG_W'(MAX_HEIGHT);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAY_MODE = 4'd0,
        CFG_WIDTH     = 4'd1,
        CFG_HEIGHT    = 4'd2,
        CFG_KERNEL_A  = 4'd3,
        CFG_KERNEL_B  = 4'd4,
        CFG_KERNEL_C  = 4'd5,
        CFG_KERNEL_D  = 4'd6,
        CFG_KERNEL_E  = 4'd7
    } cfg_reg_t;

    // side information that travels with each pixel down the pipeline
    typedef struct packed {
        logic [PIX_W-1:0] gray;
        logic             conv;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } stage_info_t;

endpackage

[rtl/gconv_pixel_if.sv]
// rgb pixel channel with valid/ready handshake
// depends on gconv_pkg

interface gconv_pixel_if
    import gconv_pkg::*;
    ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink (input valid, red, green, blue, output ready);
endinterface

[rtl/gconv_result_if.sv]
// result channel: gray value plus optional convolution result
// depends on gconv_pkg

interface gconv_result_if
    import gconv_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic [PIX_W-1:0]         gray_value;
    logic                     conv_valid;
    logic [ROW_W-1:0]         conv_row;
    logic [COL_W-1:0]         conv_col;
    logic signed [CONV_W-1:0] conv_value;
    logic                     frame_end;

    modport source (output valid, gray_value, conv_valid, conv_row, conv_col, conv_value,
                    frame_end, input ready);
    modport sink (input valid, gray_value, conv_valid, conv_row, conv_col, conv_value,
                  frame_end, output ready);
endinterface

[rtl/gconv_cfg_if.sv]
// configuration write channel: register index and data
// depends on gconv_pkg

interface gconv_cfg_if
    import gconv_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [KROW_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/grayscale_conv5x5_filter.sv]
// top level of the 5x5 gray convolution filter
// depends on gconv_pkg, the three channel interfaces, line store, cell and sum modules
//
//  channel  | dir | payload                                             | request when
//  ---------+-----+-----------------------------------------------------+-------------------
//  pixel    | in  | red, green, blue                                    | valid & ready
//  result   | out | gray_value, conv_valid/row/col/value, frame_end     | valid & ready
//  cfg      | in  | index, data (register write)                        | valid & ready
//
//  one pixel per clock sustained while result.ready is high; an accepted request passes six
//  stages, the last being the output register: line store read, window shift, cell products, row sums,
//  total, result. ready is high whenever some stage is free, so input flows while a result waits.
//  reset clears positions, valid flags, window and configuration registers; the line store holds no reset.
//  cfg.ready is always high.

module grayscale_conv5x5_filter
    import gconv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    gconv_pixel_if.sink    pixel,
    gconv_result_if.source result,
    gconv_cfg_if.sink      cfg
);

    // configuration
    logic              gray_mode_reg;
    logic [WREG_W-1:0] width_reg;
    logic [HREG_W-1:0] height_reg;
    logic [KROW_W-1:0] kernel_reg [KSIZE];

    logic [WREG_W-1:0] w_eff;
    logic [HREG_W-1:0] h_eff;

    // positions
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;

    // pipeline control
    logic a_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg, o_v_reg;
    logic a_v_next, b_v_next, c_v_next, d_v_next, e_v_next, o_v_next;
    logic a_rdy, b_rdy, c_rdy, d_rdy, e_rdy, o_rdy;
    logic a_load, b_load, c_load, d_load, e_load, o_load;

    stage_info_t       in_info;
    stage_info_t       a_info_reg, b_info_reg, c_info_reg, d_info_reg, e_info_reg;
    logic [SLOT_W-1:0] a_slot_reg;

    logic [PIX_W-1:0]  gray;
    logic [PIX_W-1:0]  ls_rd  [LINES];
    logic [PIX_W-1:0]  column [KSIZE];
    logic [PIX_W-1:0]  win    [KSIZE][KSIZE];
    logic signed [PROD_W-1:0] prod [KSIZE][KSIZE];
    logic signed [CONV_W-1:0] conv_q;

    // output register
    stage_info_t              out_info_reg;
    logic signed [CONV_W-1:0] out_conv_reg;

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_mode_reg <= 1'b0;
            width_reg     <= WIDTH_MAX;
            height_reg    <= HEIGHT_MAX;
            for (int k = 0; k < KSIZE; k++)
            begin
                kernel_reg[k] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                CFG_GRAY_MODE: gray_mode_reg <= cfg.data[0];
                CFG_WIDTH:     width_reg     <= cfg.data[WREG_W-1:0];
                CFG_HEIGHT:    height_reg    <= cfg.data[HREG_W-1:0];
                CFG_KERNEL_A:  kernel_reg[0] <= cfg.data;
                CFG_KERNEL_B:  kernel_reg[1] <= cfg.data;
                CFG_KERNEL_C:  kernel_reg[2] <= cfg.data;
                CFG_KERNEL_D:  kernel_reg[3] <= cfg.data;
                CFG_KERNEL_E:  kernel_reg[4] <= cfg.data;
                default:       ;
            endcase
        end
    end

    assign w_eff = (width_reg == '0) ? WREG_W'(1) :
                   ((width_reg > WIDTH_MAX) ? WIDTH_MAX : width_reg);
    assign h_eff = (height_reg == '0) ? HREG_W'(1) :
                   ((height_reg > HEIGHT_MAX) ? HEIGHT_MAX : height_reg);

    // gray conversion
    always_comb
    begin
        if (gray_mode_reg)
        begin
            gray = {pixel.red, 8'd0};
        end
        else
        begin
            gray = PIX_W'(GRAY_WR) * PIX_W'(pixel.red)
                 + PIX_W'(GRAY_WG) * PIX_W'(pixel.green)
                 + PIX_W'(GRAY_WB) * PIX_W'(pixel.blue);
        end
    end

    // window position and frame bookkeeping
    always_comb
    begin
        in_info.gray = gray;
        in_info.conv = (row_reg >= ROW_W'(4)) && (col_reg >= COL_W'(4))
                    && (HREG_W'(row_reg) <= h_eff - HREG_W'(1))
                    && (WREG_W'(col_reg) <= w_eff - WREG_W'(1));
        in_info.row  = row_reg - ROW_W'(2);
        in_info.col  = col_reg - COL_W'(2);
        in_info.last = (HREG_W'(row_reg) >= h_eff - HREG_W'(1))
                    && (WREG_W'(col_reg) >= w_eff - WREG_W'(1));

        row_next = row_reg;
        col_next = col_reg;
        if (WREG_W'(col_reg) + WREG_W'(1) >= w_eff)
        begin
            col_next = '0;
            if (HREG_W'(row_reg) + HREG_W'(1) >= h_eff)
            begin
                row_next = '0;
            end
            else
            begin
                row_next = row_reg + ROW_W'(1);
            end
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (a_load)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // stage ready chain; a stage takes a new request when empty or draining
    assign o_rdy = !o_v_reg || result.ready;
    assign e_rdy = !e_v_reg || o_rdy;
    assign d_rdy = !d_v_reg || e_rdy;
    assign c_rdy = !c_v_reg || d_rdy;
    assign b_rdy = !b_v_reg || c_rdy;
    assign a_rdy = !a_v_reg || b_rdy;

    assign pixel.ready = a_rdy;

    assign a_load = pixel.valid && a_rdy;
    assign b_load = a_v_reg && b_rdy;
    assign c_load = b_v_reg && c_rdy;
    assign d_load = c_v_reg && d_rdy;
    assign e_load = d_v_reg && e_rdy;
    assign o_load = e_v_reg && o_rdy;

    always_comb
    begin
        a_v_next = a_load || (a_v_reg && !b_load);
        b_v_next = b_load || (b_v_reg && !c_load);
        c_v_next = c_load || (c_v_reg && !d_load);
        d_v_next = d_load || (d_v_reg && !e_load);
        e_v_next = e_load || (e_v_reg && !o_load);
        o_v_next = o_load || (o_v_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= a_v_next;
            b_v_reg <= b_v_next;
            c_v_reg <= c_v_next;
            d_v_reg <= d_v_next;
            e_v_reg <= e_v_next;
            o_v_reg <= o_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_info_reg <= in_info;
            a_slot_reg <= row_reg[SLOT_W-1:0];
        end
        if (b_load)
        begin
            b_info_reg <= a_info_reg;
        end
        if (c_load)
        begin
            c_info_reg <= b_info_reg;
        end
        if (d_load)
        begin
            d_info_reg <= c_info_reg;
        end
        if (e_load)
        begin
            e_info_reg <= d_info_reg;
        end
        if (o_load)
        begin
            out_info_reg <= e_info_reg;
            out_conv_reg <= conv_q;
        end
    end

    gconv_line_store u_line_store (
        .clk     (clk),
        .en      (a_load),
        .slot    (row_reg[SLOT_W-1:0]),
        .addr    (col_reg),
        .wr_data (gray),
        .rd_data (ls_rd)
    );

    // oldest stored row goes to window row 0, the new pixel to row 4
    always_comb
    begin
        for (int i = 0; i < LINES; i++)
        begin
            column[i] = ls_rd[SLOT_W'(a_slot_reg + SLOT_W'(i))];
        end
        column[KSIZE-1] = a_info_reg.gray;
    end

    for (genvar gr = 0; gr < KSIZE; gr++)
    begin : g_row
        for (genvar gc = 0; gc < KSIZE; gc++)
        begin : g_col
            logic [PIX_W-1:0] cell_in;

            if (gc == KSIZE - 1)
            begin : g_entry
                assign cell_in = column[gr];
            end
            else
            begin : g_link
                assign cell_in = win[gr][gc+1];
            end

            gconv_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (b_load),
                .prod_en  (c_load),
                .pix_in   (cell_in),
                .coef     (kernel_reg[gr][COEF_W*gc +: COEF_W]),
                .pix_out  (win[gr][gc]),
                .prod     (prod[gr][gc])
            );
        end
    end

    gconv_sum u_sum (
        .clk      (clk),
        .row_en   (d_load),
        .total_en (e_load),
        .prod     (prod),
        .conv_q   (conv_q)
    );

    // convolution fields read zero when no convolution result goes with the pixel
    assign result.valid      = o_v_reg;
    assign result.gray_value = out_info_reg.gray;
    assign result.conv_valid = out_info_reg.conv;
    assign result.conv_row   = out_info_reg.conv ? out_info_reg.row : '0;
    assign result.conv_col   = out_info_reg.conv ? out_info_reg.col : '0;
    assign result.conv_value = out_info_reg.conv ? out_conv_reg : '0;
    assign result.frame_end  = out_info_reg.last;

endmodule

[rtl/gconv_line_store.sv]
// four line stores, one per row slot, each MAX_WIDTH x 16 bit
// depends on gconv_pkg; all lanes read at one column, one lane written

module gconv_line_store
    import gconv_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [SLOT_W-1:0] slot,
    input  logic [COL_W-1:0]  addr,
    input  logic [PIX_W-1:0]  wr_data,
    output logic [PIX_W-1:0]  rd_data [LINES]
);

    for (genvar k = 0; k < LINES; k++)
    begin : g_lane
        logic [PIX_W-1:0] mem [MAX_WIDTH];
        logic [PIX_W-1:0] rd_reg;

        // read returns the old word when the same entry is written
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rd_reg <= mem[addr];
                if (slot == SLOT_W'(k))
                begin
                    mem[addr] <= wr_data;
                end
            end
        end

        assign rd_data[k] = rd_reg;
    end

endmodule

[rtl/gconv_cell.sv]
// one window cell: holds a pixel, passes it on, forms its weighted product
// depends on gconv_pkg

module gconv_cell
    import gconv_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     shift_en,
    input  logic                     prod_en,
    input  logic [PIX_W-1:0]         pix_in,
    input  logic signed [COEF_W-1:0] coef,
    output logic [PIX_W-1:0]         pix_out,
    output logic signed [PROD_W-1:0] prod
);

    logic [PIX_W-1:0]         pix_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = $signed({1'b0, pix_reg}) * coef;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg <= '0;
        end
        else if (shift_en)
        begin
            pix_reg <= pix_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign pix_out = pix_reg;
    assign prod    = prod_reg;

endmodule

[rtl/gconv_sum.sv]
// registered adder tree over the 25 cell products, then scaling by 1/256
// depends on gconv_pkg; row sums first, then the total

module gconv_sum
    import gconv_pkg::*;
(
    input  logic                     clk,
    input  logic                     row_en,
    input  logic                     total_en,
    input  logic signed [PROD_W-1:0] prod [KSIZE][KSIZE],
    output logic signed [CONV_W-1:0] conv_q
);

    logic signed [RSUM_W-1:0] rsum_reg  [KSIZE];
    logic signed [RSUM_W-1:0] rsum_next [KSIZE];
    logic signed [SUM_W-1:0]  total_reg;
    logic signed [SUM_W-1:0]  total_next;
    logic signed [SUM_W-1:0]  biased;

    always_comb
    begin
        for (int r = 0; r < KSIZE; r++)
        begin
            rsum_next[r] = '0;
            for (int c = 0; c < KSIZE; c++)
            begin
                rsum_next[r] = rsum_next[r] + RSUM_W'(prod[r][c]);
            end
        end
    end

    always_comb
    begin
        total_next = '0;
        for (int r = 0; r < KSIZE; r++)
        begin
            total_next = total_next + SUM_W'(rsum_reg[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_en)
        begin
            rsum_reg <= rsum_next;
        end
        if (total_en)
        begin
            total_reg <= total_next;
        end
    end

    // truncate toward zero: negative sums get 255 added before the shift
    assign biased = total_reg + (total_reg[SUM_W-1] ? SUM_W'(255) : SUM_W'(0));
    assign conv_q = biased[CONV_W+FRAC_W-1:FRAC_W];

endmodule

[rtl/gconv_checker.sv]
// port-level checks for the 5x5 gray convolution filter, bound to the top level
// depends on gconv_pkg

module gconv_checker
    import gconv_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [PIX_W-1:0]         gray_value,
    input logic                     conv_valid,
    input logic [ROW_W-1:0]         conv_row,
    input logic [COL_W-1:0]         conv_col,
    input logic signed [CONV_W-1:0] conv_value
);

    logic [2:0] occ_reg;
    logic [2:0] occ_next;

    // requests accepted but not yet delivered
    always_comb
    begin
        occ_next = occ_reg;
        if (in_valid && in_ready && !(out_valid && out_ready))
        begin
            occ_next = occ_reg + 3'd1;
        end
        else if (!(in_valid && in_ready) && out_valid && out_ready)
        begin
            occ_next = occ_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(gray_value) && $stable(conv_value))
        else $error("result changed while stalled");

    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !conv_valid |-> conv_row == '0 && conv_col == '0 && conv_value == '0)
        else $error("convolution fields set without a result");

    a_centre_inside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && conv_valid |-> conv_row >= ROW_W'(2) && conv_col >= COL_W'(2))
        else $error("window centre on the border");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == 3'd0 |-> !out_valid)
        else $error("result without an accepted pixel");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= 3'(PIPE_DEPTH))
        else $error("more pixels in flight than pipeline stages");

endmodule

bind grayscale_conv5x5_filter gconv_checker u_gconv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pixel.valid),
    .in_ready   (pixel.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .gray_value (result.gray_value),
    .conv_valid (result.conv_valid),
    .conv_row   (result.conv_row),
    .conv_col   (result.conv_col),
    .conv_value (result.conv_value)
);
